// File: rtl/core/icsd_pkg.sv
// Shared types and constants of the input channel smoother and debouncer.
// Used by every module under rtl/core; depends on nothing.
package icsd_pkg;

  localparam int NumChannels = 8;
  localparam int NumSwitches = 8;
  localparam int SampleBits  = 12;

  localparam int ChanW    = 3;
  localparam int SmpW     = 12;
  localparam int PinW     = 8;
  localparam int CfgW     = 8;
  localparam int CfgIdxW  = 2;
  localparam int ChanIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int PinExtW  = (NumSwitches > PinW) ? NumSwitches : PinW;

  localparam int ProdW = SmpW + CfgW;
  localparam int NumW  = ProdW + 1;
  localparam int DenW  = CfgW + 1;
  localparam int DivCntW = $clog2(NumW + 1);

  localparam int CmdDepth = 2;
  localparam int CmdPtrW  = 1;
  localparam int CmdCntW  = $clog2(CmdDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgWeightNew = 2'd0,
    CfgWeightOld = 2'd1,
    CfgDebounce  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KindAnalog = 1'b0,
    KindTick   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic             chan_ok;
    logic [ChanW-1:0] channel;
    logic [SmpW-1:0]  sample;
    logic [PinW-1:0]  pins;
  } cmd_t;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [SmpW-1:0]  value;
    logic [PinW-1:0]  flags;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

endpackage

// File: rtl/core/icsd_front.sv
// Front end: classifies incoming transactions and queues them as commands.
// Depends on icsd_pkg.
module icsd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      kind_i,
  input  logic [icsd_pkg::ChanW-1:0] channel_i,
  input  logic [icsd_pkg::SmpW-1:0]  sample_i,
  input  logic [icsd_pkg::PinW-1:0]  switch_pins_i,
  output logic                      cmd_valid_o,
  output icsd_pkg::cmd_t            cmd_o,
  input  logic                      cmd_pop_i
);

  icsd_pkg::cmd_t                     mem_q [icsd_pkg::CmdDepth];
  logic [icsd_pkg::CmdPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [icsd_pkg::CmdCntW-1:0]       cnt_q;
  icsd_pkg::cmd_t                     cmd_new;
  logic                               do_wr, do_rd;

  always_comb begin
    cmd_new.kind    = icsd_pkg::kind_e'(kind_i);
    cmd_new.chan_ok = int'(channel_i) < icsd_pkg::NumChannels;
    cmd_new.channel = channel_i;
    cmd_new.sample  = sample_i & icsd_pkg::SmpW'((1 << icsd_pkg::SampleBits) - 1);
    cmd_new.pins    = switch_pins_i;
  end

  assign full        = (cnt_q == icsd_pkg::CmdCntW'(icsd_pkg::CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_wr       = push && !full;
  assign do_rd       = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: rtl/core/icsd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on icsd_pkg.
module icsd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  icsd_pkg::div_req_t          req_i,
  output logic                        done_o,
  output logic [icsd_pkg::NumW-1:0]   quo_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [icsd_pkg::DivCntW-1:0]       cnt_q;
  logic [icsd_pkg::NumW-1:0]          quo_q;
  logic [icsd_pkg::DenW-1:0]          rem_q;
  logic [icsd_pkg::DenW-1:0]          den_q;
  logic [icsd_pkg::DenW:0]            rem_sh;
  logic                               ge;

  assign rem_sh = {rem_q, quo_q[icsd_pkg::NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == icsd_pkg::DivCntW'(icsd_pkg::NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[icsd_pkg::NumW-2:0], ge};
      rem_q <= ge ? icsd_pkg::DenW'(rem_sh - {1'b0, den_q})
                  : icsd_pkg::DenW'(rem_sh);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/icsd_back.sv
// Back end: holds channel values, switch flags, lockout counters and the
// settings; runs each command and posts its result. Depends on icsd_pkg, icsd_div.
module icsd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  icsd_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  input  logic                        pop,
  output logic                        empty,
  output icsd_pkg::result_t           result_o,
  input  logic                        cfg_we_i,
  input  logic [icsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [icsd_pkg::CfgW-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSum,
    StDiv,
    StDone
  } state_e;

  state_e                             state_q;
  icsd_pkg::cmd_t                     cur_q;
  logic [icsd_pkg::SmpW-1:0]          value_q;
  logic [icsd_pkg::ProdW-1:0]         prod_new_q, prod_old_q;
  logic [icsd_pkg::SmpW-1:0]          smoothed_q [icsd_pkg::NumChannels];
  logic [icsd_pkg::NumSwitches-1:0]   flags_q, flags_d;
  logic [icsd_pkg::CfgW-1:0]          lock_q [icsd_pkg::NumSwitches];
  logic [icsd_pkg::CfgW-1:0]          lock_d [icsd_pkg::NumSwitches];
  logic [icsd_pkg::CfgW-1:0]          w_new_q, w_old_q, deb_q;
  icsd_pkg::result_t                  out_q;
  logic                               out_valid_q;
  logic                               out_free;
  logic [icsd_pkg::SmpW-1:0]          old_rd;
  logic [icsd_pkg::DenW-1:0]          den;
  logic [icsd_pkg::PinExtW-1:0]       pins_ext;
  icsd_pkg::div_req_t                 div_req;
  logic                               div_done;
  logic [icsd_pkg::NumW-1:0]          div_quo;

  assign out_free  = !out_valid_q || pop;
  assign cmd_pop_o = (state_q == StIdle) && cmd_valid_i;
  assign empty     = !out_valid_q;
  assign result_o  = out_q;
  assign old_rd    = smoothed_q[icsd_pkg::ChanIdxW'(cur_q.channel)];
  assign den       = icsd_pkg::DenW'(w_new_q) + icsd_pkg::DenW'(w_old_q);
  assign pins_ext  = icsd_pkg::PinExtW'(cur_q.pins);

  assign div_req.start = (state_q == StSum);
  assign div_req.num   = icsd_pkg::NumW'(prod_new_q) + icsd_pkg::NumW'(prod_old_q);
  assign div_req.den   = den;

  icsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Debounce update for a tick; each switch is independent.
  always_comb begin
    flags_d = flags_q;
    for (int i = 0; i < icsd_pkg::NumSwitches; i++) begin
      lock_d[i] = lock_q[i];
      if (lock_q[i] == '0) begin
        if (pins_ext[i] != flags_q[i]) begin
          flags_d[i] = pins_ext[i];
          lock_d[i]  = deb_q;
        end
      end else begin
        lock_d[i] = lock_q[i] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      w_new_q     <= icsd_pkg::CfgW'(1);
      w_old_q     <= icsd_pkg::CfgW'(3);
      deb_q       <= icsd_pkg::CfgW'(5);
      for (int i = 0; i < icsd_pkg::NumChannels; i++) begin
        smoothed_q[i] <= '0;
      end
      for (int i = 0; i < icsd_pkg::NumSwitches; i++) begin
        lock_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (icsd_pkg::cfg_idx_e'(cfg_idx_i))
          icsd_pkg::CfgWeightNew: w_new_q <= cfg_data_i;
          icsd_pkg::CfgWeightOld: w_old_q <= cfg_data_i;
          icsd_pkg::CfgDebounce:  deb_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cur_q   <= cmd_i;
            value_q <= '0;
            if (cmd_i.kind == icsd_pkg::KindTick || !cmd_i.chan_ok) begin
              state_q <= StDone;
            end else begin
              state_q <= StMul;
            end
          end
        end
        StMul: begin
          prod_new_q <= icsd_pkg::ProdW'(cur_q.sample) * icsd_pkg::ProdW'(w_new_q);
          prod_old_q <= icsd_pkg::ProdW'(old_rd) * icsd_pkg::ProdW'(w_old_q);
          value_q    <= old_rd;
          state_q    <= (den == '0) ? StDone : StSum;
        end
        StSum: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (div_done) begin
            value_q <= icsd_pkg::SmpW'(div_quo);
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
            if (cur_q.kind == icsd_pkg::KindTick) begin
              out_q.channel <= '0;
              out_q.value   <= '0;
              out_q.flags   <= icsd_pkg::PinW'(flags_d);
              flags_q       <= flags_d;
              for (int i = 0; i < icsd_pkg::NumSwitches; i++) begin
                lock_q[i] <= lock_d[i];
              end
            end else begin
              out_q.channel <= cur_q.channel;
              out_q.value   <= value_q;
              out_q.flags   <= icsd_pkg::PinW'(flags_q);
              if (cur_q.chan_ok) begin
                smoothed_q[icsd_pkg::ChanIdxW'(cur_q.channel)] <= value_q;
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: rtl/core/input_channel_smoother_debouncer.sv
// Top level of the input channel smoother and switch debouncer.
// Depends on icsd_pkg, icsd_front, icsd_back (and icsd_div below it).
//
// Usage:
//   Input queue: drive kind_i/channel_i/sample_i/switch_pins_i with push high;
//   the transaction is taken when full is low. Kind 0 is an analog sample that
//   updates one channel's weighted average, kind 1 a poll tick with all pins.
//   Result queue: while empty is low the ports show the oldest result; pop
//   takes it. Every transaction gives exactly one result, in order.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 weight_new,
//   1 weight_old, 2 debounce_ticks) at once; write only while idle.
// Flow:
//   A tick goes from the command queue straight to StDone and the result register. An
//   analog sample is read and multiplied, summed, then divided one bit per cycle;
//   both weights zero skips the divide.
//   A two-entry command queue lets the front keep taking transactions while
//   the back works or waits on a held result.
// Reset clears all channel values, flags and counters and restores the
// register defaults (1, 3, 5). If pop stays low the back holds its finished
// result, then the command queue fills and full rises.
module input_channel_smoother_debouncer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind_i,
  input  logic [icsd_pkg::ChanW-1:0]   channel_i,
  input  logic [icsd_pkg::SmpW-1:0]    sample_i,
  input  logic [icsd_pkg::PinW-1:0]    switch_pins_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [icsd_pkg::ChanW-1:0]   channel_out_o,
  output logic [icsd_pkg::SmpW-1:0]    smoothed_value_o,
  output logic [icsd_pkg::PinW-1:0]    switch_states_o,
  input  logic                         cfg_we_i,
  input  logic [icsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [icsd_pkg::CfgW-1:0]    cfg_data_i
);

  logic              cmd_valid;
  logic              cmd_pop;
  icsd_pkg::cmd_t    cmd;
  icsd_pkg::result_t result;

  icsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .switch_pins_i (switch_pins_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  icsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .result_o    (result),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  assign channel_out_o    = result.channel;
  assign smoothed_value_o = result.value;
  assign switch_states_o  = result.flags;

endmodule

// File: rtl/core/icsd_checker.sv
// Port-level checks for input_channel_smoother_debouncer, bound to the top.
// Depends on icsd_pkg.
module icsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [icsd_pkg::ChanW-1:0]   channel_out_o,
  input logic [icsd_pkg::SmpW-1:0]    smoothed_value_o,
  input logic [icsd_pkg::PinW-1:0]    switch_states_o,
  input logic                         cfg_we_i
);

  // held result stays put until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(channel_out_o) &&
      $stable(smoothed_value_o) && $stable(switch_states_o)))
    else $error("result changed while stalled");

  // a result leaves only when popped
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result dropped without pop");

  // the input queue fills only on an accepted transaction
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full without a push");

  // a presented result carries known values
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown({channel_out_o, smoothed_value_o, switch_states_o}))
    else $error("unknown bits on a presented result");

  // register writes come only while no result is held and the command queue is not full
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (empty && !full))
    else $error("register write while busy");

endmodule

bind input_channel_smoother_debouncer icsd_checker u_checker (.*);

// File: bench/icsd_channel_checker.sv
`timescale 1ns / 100ps
// Checker for the input channel smoother and debouncer: mirrors the channel table,
// switch flags, lockout counters and registers, predicts every report and compares
// it when popped. Depends on icsd_pkg only.
module icsd_channel_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic                         kind_i,
  input  logic [icsd_pkg::ChanW-1:0]   channel_i,
  input  logic [icsd_pkg::SmpW-1:0]    sample_i,
  input  logic [icsd_pkg::PinW-1:0]    switch_pins_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic [icsd_pkg::ChanW-1:0]   channel_out_i,
  input  logic [icsd_pkg::SmpW-1:0]    smoothed_value_i,
  input  logic [icsd_pkg::PinW-1:0]    switch_states_i,
  input  logic                         cfg_we_i,
  input  logic [icsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [icsd_pkg::CfgW-1:0]    cfg_data_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  awaited_o,
  output int unsigned                  reports_o
);
  import icsd_pkg::*;

  localparam int unsigned ReportLimit = 10;

  logic [CfgW-1:0]        weight_new_q = 8'd1;
  logic [CfgW-1:0]        weight_old_q = 8'd3;
  logic [CfgW-1:0]        lockout_ticks_q = 8'd5;
  logic [SmpW-1:0]        chan_value [NumChannels];
  logic [NumSwitches-1:0] pressed;
  logic [CfgW-1:0]        lockout [NumSwitches];
  result_t                awaited_reports [$];

  initial begin
    mismatches_o = 0;
    awaited_o = 0;
    reports_o = 0;
  end

  function automatic result_t filter_and_debounce(logic kind, logic [ChanW-1:0] chan,
                                                  logic [SmpW-1:0] smp,
                                                  logic [PinW-1:0] pins);
    result_t     rep;
    int unsigned num;
    int unsigned den;
    rep = '0;
    if (kind == KindAnalog) begin
      den = 32'(weight_new_q) + 32'(weight_old_q);
      if (den != 0) begin
        num = 32'(smp) * 32'(weight_new_q) + 32'(chan_value[chan]) * 32'(weight_old_q);
        chan_value[chan] = SmpW'(num / den);
      end
      rep.channel = chan;
      rep.value = chan_value[chan];
    end else begin
      for (int i = 0; i < NumSwitches; i++) begin
        if (lockout[i] == 0) begin
          if (pins[i] != pressed[i]) begin
            pressed[i] = pins[i];
            lockout[i] = lockout_ticks_q;
          end
        end else begin
          lockout[i] = lockout[i] - 1'b1;
        end
      end
    end
    rep.flags = PinW'(pressed);
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      weight_new_q = 8'd1;
      weight_old_q = 8'd3;
      lockout_ticks_q = 8'd5;
      pressed = '0;
      for (int i = 0; i < NumChannels; i++) chan_value[i] = '0;
      for (int i = 0; i < NumSwitches; i++) lockout[i] = '0;
      awaited_reports.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgWeightNew: weight_new_q = cfg_data_i;
          CfgWeightOld: weight_old_q = cfg_data_i;
          CfgDebounce:  lockout_ticks_q = cfg_data_i;
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        got.channel = channel_out_i;
        got.value = smoothed_value_i;
        got.flags = switch_states_i;
        reports_o++;
        if (awaited_reports.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= ReportLimit)
            $display("report %0d with no transaction outstanding: channel %0d value %0d switches %b",
                     reports_o, got.channel, got.value, got.flags);
        end else begin
          want = awaited_reports.pop_front();
          if (got.channel !== want.channel || got.value !== want.value ||
              got.flags !== want.flags) begin
            mismatches_o++;
            if (mismatches_o <= ReportLimit)
              $display("report %0d: expected channel %0d value %0d switches %b, got %0d %0d %b",
                       reports_o, want.channel, want.value, want.flags,
                       got.channel, got.value, got.flags);
          end
        end
      end
      if (push_i && !full_i)
        awaited_reports.push_back(filter_and_debounce(kind_i, channel_i, sample_i,
                                                      switch_pins_i));
    end
    awaited_o = awaited_reports.size();
  end

endmodule

// File: bench/input_channel_smoother_debouncer_test.sv
`timescale 1ns / 100ps
// Regression top for the input channel smoother and debouncer: drives samples, polls
// and register writes, and gives the verdict. Depends on icsd_pkg, the block and
// icsd_channel_checker.
module input_channel_smoother_debouncer_test;
  import icsd_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int          MaxGap       = 18;
  localparam int          LongHold     = 400;
  localparam int          TailCycles   = 40;
  localparam int          RandomPhases = 8;
  localparam int          PhaseItems   = 242;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic             kind = 1'b0;
  logic [ChanW-1:0] channel = '0;
  logic [SmpW-1:0]  sample = '0;
  logic [PinW-1:0]  pins = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic [ChanW-1:0] channel_out;
  logic [SmpW-1:0]  smoothed_value;
  logic [PinW-1:0]  switch_states;
  logic             cfg_we = 1'b0;
  cfg_idx_e         cfg_idx = CfgWeightNew;
  logic [CfgW-1:0]  cfg_data = '0;

  int unsigned      mismatches;
  int unsigned      awaited;
  int unsigned      reports;
  int unsigned      cycles = 0;
  int               send_gap_max = MaxGap;
  int               recv_gap_max = MaxGap;
  bit               hold_req = 1'b0;
  int               holds_done = 0;
  int               analog_sent = 0;
  int               ticks_sent = 0;
  int               settings_used = 1;
  logic [PinW-1:0]  pin_level = '0;

  input_channel_smoother_debouncer i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .kind_i           (kind),
    .channel_i        (channel),
    .sample_i         (sample),
    .switch_pins_i    (pins),
    .empty            (empty),
    .pop              (pop),
    .channel_out_o    (channel_out),
    .smoothed_value_o (smoothed_value),
    .switch_states_o  (switch_states),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  icsd_channel_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .kind_i           (kind),
    .channel_i        (channel),
    .sample_i         (sample),
    .switch_pins_i    (pins),
    .empty_i          (empty),
    .pop_i            (pop),
    .channel_out_i    (channel_out),
    .smoothed_value_i (smoothed_value),
    .switch_states_i  (switch_states),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatches_o     (mismatches),
    .awaited_o        (awaited),
    .reports_o        (reports)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random pop gaps, plus a long hold-off on request
  initial begin : result_drain
    int wait_cycles;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        wait_cycles = LongHold;
      end else begin
        wait_cycles = $urandom_range(recv_gap_max, 0);
      end
      if (wait_cycles != 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  task automatic offer(kind_e k, logic [ChanW-1:0] ch, logic [SmpW-1:0] smp,
                       logic [PinW-1:0] p);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    channel <= ch;
    sample <= smp;
    pins <= p;
    do @(posedge clk); while (full);
    if (k == KindTick) ticks_sent++;
    else analog_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic write_regs(logic [CfgW-1:0] wn, logic [CfgW-1:0] wo, logic [CfgW-1:0] dt);
    cfg_we <= 1'b1;
    cfg_idx <= CfgWeightNew;
    cfg_data <= wn;
    @(posedge clk);
    cfg_idx <= CfgWeightOld;
    cfg_data <= wo;
    @(posedge clk);
    cfg_idx <= CfgDebounce;
    cfg_data <= dt;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [CfgW-1:0] pick_weight();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return 8'd1;
      default: return CfgW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_lockout();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return CfgW'($urandom);
      default: return CfgW'($urandom_range(6, 1));
    endcase
  endfunction

  // pins mostly drift a few bits per poll so lockouts and toggles line up
  task automatic random_item();
    logic [SmpW-1:0] smp;
    case ($urandom_range(7, 0))
      0: smp = '0;
      1: smp = '1;
      default: smp = SmpW'($urandom);
    endcase
    if ($urandom_range(1, 0) == 0) begin
      offer(KindAnalog, ChanW'($urandom), smp, PinW'($urandom));
    end else begin
      if ($urandom_range(7, 0) == 0) pin_level = PinW'($urandom);
      else pin_level ^= PinW'($urandom & $urandom & $urandom);
      offer(KindTick, ChanW'($urandom), smp, pin_level);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    offer(KindAnalog, 3'd0, 12'hFFF, 8'h00);
    offer(KindAnalog, 3'd7, 12'h000, 8'hFF);
    offer(KindAnalog, 3'd5, 12'hAAA, 8'h00);
    offer(KindTick, 3'd0, 12'h000, 8'hFF);
    offer(KindTick, 3'd0, 12'h000, 8'h00);
    offer(KindTick, 3'd0, 12'h000, 8'h55);
    settle();
    // widest weights, no lockout
    write_regs(8'hFF, 8'hFF, 8'h00);
    offer(KindAnalog, 3'd0, 12'hFFF, 8'h00);
    offer(KindAnalog, 3'd1, 12'h555, 8'h00);
    offer(KindTick, 3'd0, 12'h000, 8'h00);
    offer(KindTick, 3'd0, 12'h000, 8'hF0);
    offer(KindTick, 3'd0, 12'h000, 8'h0F);
    settle();
    // both weights zero keeps the stored value, longest lockout
    write_regs(8'h00, 8'h00, 8'hFF);
    offer(KindAnalog, 3'd0, 12'd123, 8'h00);
    offer(KindAnalog, 3'd6, 12'hFFF, 8'h00);
    offer(KindTick, 3'd0, 12'h000, 8'hFF);
    offer(KindTick, 3'd0, 12'h000, 8'h00);
    settle();
    write_regs(8'hFF, 8'h00, 8'h05);
    offer(KindAnalog, 3'd2, 12'hFFF, 8'h00);
    offer(KindAnalog, 3'd2, 12'h000, 8'h00);
    settle();
    write_regs(8'h00, 8'hFF, 8'h05);
    offer(KindAnalog, 3'd2, 12'hFFF, 8'h00);
    settle();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      write_regs(pick_weight(), pick_weight(), pick_lockout());
      send_gap_max = (phase % 3 == 1) ? 0 : MaxGap;
      recv_gap_max = (phase % 3 == 2) ? 0 : MaxGap;
      if (phase == 1 || phase == 5) begin
        send_gap_max = 0;
        hold_req = 1'b1;
      end
      repeat (PhaseItems) random_item();
      settle();
    end

    repeat (TailCycles) @(posedge clk);
    $display("covered %0d analog samples and %0d switch polls under %0d register settings,",
             analog_sent, ticks_sent, settings_used);
    $display("%0d reports checked, %0d long result stalls, %0d mismatches",
             reports, holds_done, mismatches);
    if (mismatches == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: input_channel_smoother_debouncer.f
rtl/core/icsd_pkg.sv
rtl/core/icsd_front.sv
rtl/core/icsd_div.sv
rtl/core/icsd_back.sv
rtl/core/input_channel_smoother_debouncer.sv
rtl/core/icsd_checker.sv
bench/icsd_channel_checker.sv
bench/input_channel_smoother_debouncer_test.sv
